### rtl/core/gbca_pkg.sv
package gbca_pkg;

    // Fixed geometry of the block.
    localparam int MAX_GLYPH_WIDTH  = 40;
    localparam int MAX_GLYPH_HEIGHT = 40;
    localparam int MAX_ROWS         = 40;
    localparam int ROW_BITS         = 40;
    localparam int BYTE_BITS        = 8;
    localparam int MAX_ROW_BYTES    = ROW_BITS / BYTE_BITS;
    localparam int CMD_DEPTH        = 2;

    localparam logic [5:0] CELL_HEIGHT_RESET = 6'd16;
    localparam logic [5:0] CELL_WIDTH_RESET  = 6'd8;

    typedef logic [ROW_BITS-1:0] row_t;

    // Input item kinds, carried on the slave tuser bit.
    typedef enum logic
    {
        KIND_HEADER = 1'b0,
        KIND_ROW    = 1'b1
    } kind_t;

    // Configuration register indexes.
    typedef enum logic
    {
        REG_CELL_HEIGHT = 1'b0,
        REG_CELL_WIDTH  = 1'b1
    } reg_index_t;

    // Command handed from the front to the back through the queue.
    typedef struct packed
    {
        logic       is_row;
        logic       passthrough;
        logic [6:0] shift;
        logic [2:0] dest_bytes;
        logic [2:0] src_bytes;
        logic [5:0] pad_limit;
        row_t       src;
        logic       last;
    } cmd_t;

    // Cell height actually used: limited by the build limits.
    function automatic logic [5:0] eff_height(input logic [5:0] h);
        logic [5:0] r;
        r = h;
        if (r > 6'(MAX_GLYPH_HEIGHT))
        begin
            r = 6'(MAX_GLYPH_HEIGHT);
        end
        if (r > 6'(MAX_ROWS))
        begin
            r = 6'(MAX_ROWS);
        end
        return r;
    endfunction

    // Bytes needed for a width in pixels, held within one to five.
    function automatic logic [2:0] byte_count(input logic [5:0] w);
        logic [6:0] wc;
        logic [6:0] b;
        wc = {1'b0, w};
        if (wc > 7'(MAX_GLYPH_WIDTH))
        begin
            wc = 7'(MAX_GLYPH_WIDTH);
        end
        b = (wc + 7'(BYTE_BITS - 1)) >> 3;
        if (b < 7'd1)
        begin
            b = 7'd1;
        end
        if (b > 7'(MAX_ROW_BYTES))
        begin
            b = 7'(MAX_ROW_BYTES);
        end
        return b[2:0];
    endfunction

    // Mask that keeps the first bytes of a row, which sit in the top bits.
    function automatic row_t top_mask(input logic [2:0] bytes);
        logic [5:0] bits;
        row_t       m;
        bits = {bytes, 3'b000};
        if (bits == 6'd0)
        begin
            m = '0;
        end
        else if (bits >= 6'(ROW_BITS))
        begin
            m = '1;
        end
        else
        begin
            m = ~({ROW_BITS{1'b1}} >> bits);
        end
        return m;
    endfunction

    // Signed horizontal shift: positive moves right, bits past either edge drop.
    function automatic row_t shift_row(input row_t src, input logic [6:0] shift);
        logic [6:0] mag;
        row_t       v;
        mag = 7'(-shift);
        if (!shift[6])
        begin
            v = (shift >= 7'(ROW_BITS)) ? '0 : (src >> shift);
        end
        else
        begin
            v = (mag >= 7'(ROW_BITS)) ? '0 : (src << mag);
        end
        return v;
    endfunction

endpackage

### rtl/core/gbca_front.sv
module gbca_front
    import gbca_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        in_kind,
    input  logic [71:0] in_data,
    input  logic [5:0]  height,
    input  logic [5:0]  cell_width,
    output logic        push,
    output cmd_t        push_cmd,
    input  logic        queue_full
);

    logic [5:0]        rows_rem_reg;
    logic [5:0]        rows_rem_next;
    logic [2:0]        src_bytes_reg;
    logic [2:0]        src_bytes_next;

    logic              accept;
    logic [5:0]        aw;
    logic [5:0]        gw;
    logic [5:0]        gh;
    logic [6:0]        ox;
    logic [6:0]        oy;
    row_t              src;
    logic              pass;
    logic signed [8:0] top_s;
    logic [5:0]        top;
    logic [5:0]        gh_clamped;

    // Unpack the header and row fields.
    assign aw  = in_data[5:0];
    assign gw  = in_data[11:6];
    assign gh  = in_data[17:12];
    assign ox  = in_data[24:18];
    assign oy  = in_data[31:25];
    assign src = in_data[71:32];

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    // Header classification: passthrough test and top padding count.
    always_comb
    begin
        pass  = (gw == cell_width) && (ox == 7'd0) && (oy == 7'd0);
        top_s = $signed({3'b000, height}) - $signed({3'b000, gh})
                - $signed({{2{oy[6]}}, oy});
        if (top_s < 0)
        begin
            top = 6'd0;
        end
        else if (top_s > $signed({3'b000, height}))
        begin
            top = height;
        end
        else
        begin
            top = top_s[5:0];
        end
        gh_clamped = (gh > 6'(MAX_GLYPH_HEIGHT)) ? 6'(MAX_GLYPH_HEIGHT) : gh;
    end

    // Build the command for the back and track pending source rows.
    always_comb
    begin
        rows_rem_next  = rows_rem_reg;
        src_bytes_next = src_bytes_reg;
        push           = 1'b0;
        push_cmd       = '0;
        push_cmd.shift      = ox;
        push_cmd.dest_bytes = byte_count(aw);
        push_cmd.src_bytes  = byte_count(gw);
        push_cmd.passthrough = pass;
        if (accept)
        begin
            if (in_kind == KIND_HEADER)
            begin
                push           = 1'b1;
                src_bytes_next = byte_count(gw);
                if (pass)
                begin
                    rows_rem_next      = gh_clamped;
                    push_cmd.pad_limit = 6'd0;
                end
                else
                begin
                    rows_rem_next      = gh;
                    push_cmd.pad_limit = (gh == 6'd0) ? height : top;
                end
            end
            else if (rows_rem_reg != 6'd0)
            begin
                // Stray rows with nothing pending are dropped here.
                push            = 1'b1;
                rows_rem_next   = rows_rem_reg - 6'd1;
                push_cmd.is_row = 1'b1;
                push_cmd.src    = src & top_mask(src_bytes_reg);
                push_cmd.last   = (rows_rem_reg == 6'd1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_rem_reg  <= '0;
            src_bytes_reg <= '0;
        end
        else
        begin
            rows_rem_reg  <= rows_rem_next;
            src_bytes_reg <= src_bytes_next;
        end
    end

endmodule

### rtl/core/gbca_cmd_fifo.sv
module gbca_cmd_fifo
    import gbca_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output cmd_t head,
    output logic empty
);

    localparam int PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
    localparam int CNT_W = $clog2(CMD_DEPTH + 1);

    cmd_t             mem_reg [CMD_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(CMD_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    // Storage of queued commands.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(CMD_DEPTH - 1)) ? '0
                                                                    : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(CMD_DEPTH - 1)) ? '0
                                                                    : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### rtl/core/gbca_back.sv
module gbca_back
    import gbca_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        head,
    input  logic        empty,
    output logic        pop,
    input  logic [5:0]  height,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [55:0] out_data,
    output logic        out_last,
    output logic        out_eog
);

    // Glyph context loaded by each header.
    logic [6:0] shift_reg;
    logic [6:0] shift_next;
    logic [2:0] dest_bytes_reg;
    logic [2:0] dest_bytes_next;
    logic [2:0] src_bytes_reg;
    logic [2:0] src_bytes_next;
    logic       pass_reg;
    logic       pass_next;
    logic [5:0] next_row_reg;
    logic [5:0] next_row_next;
    logic       padding_reg;
    logic       padding_next;
    logic [5:0] pad_lim_reg;
    logic [5:0] pad_lim_next;

    // Output register.
    logic       out_valid_reg;
    logic       out_valid_next;
    row_t       row_reg;
    row_t       row_next;
    logic [2:0] bytes_reg;
    logic [2:0] bytes_next;
    logic [5:0] num_reg;
    logic [5:0] num_next;
    logic       eor_reg;
    logic       eor_next;
    logic       eog_reg;
    logic       eog_next;

    logic       slot_free;
    logic       emit;
    logic [6:0] row_inc;

    assign slot_free = !out_valid_reg || out_ready;
    assign row_inc   = {1'b0, next_row_reg} + 7'd1;

    // Row sequencer: padding runs first, otherwise the queue head is executed.
    always_comb
    begin
        shift_next      = shift_reg;
        dest_bytes_next = dest_bytes_reg;
        src_bytes_next  = src_bytes_reg;
        pass_next       = pass_reg;
        next_row_next   = next_row_reg;
        padding_next    = padding_reg;
        pad_lim_next    = pad_lim_reg;
        pop             = 1'b0;
        emit            = 1'b0;
        row_next        = row_reg;
        bytes_next      = bytes_reg;
        num_next        = num_reg;
        eor_next        = eor_reg;
        eog_next        = eog_reg;

        if (slot_free)
        begin
            if (padding_reg)
            begin
                emit          = 1'b1;
                row_next      = '0;
                bytes_next    = dest_bytes_reg;
                num_next      = next_row_reg;
                eog_next      = (row_inc == {1'b0, height});
                eor_next      = (row_inc == {1'b0, pad_lim_reg});
                next_row_next = row_inc[5:0];
                padding_next  = (row_inc < {1'b0, pad_lim_reg});
            end
            else if (!empty)
            begin
                pop = 1'b1;
                if (!head.is_row)
                begin
                    shift_next      = head.shift;
                    dest_bytes_next = head.dest_bytes;
                    src_bytes_next  = head.src_bytes;
                    pass_next       = head.passthrough;
                    next_row_next   = 6'd0;
                    if (head.pad_limit != 6'd0)
                    begin
                        emit          = 1'b1;
                        row_next      = '0;
                        bytes_next    = head.dest_bytes;
                        num_next      = 6'd0;
                        eog_next      = (height == 6'd1);
                        eor_next      = (head.pad_limit == 6'd1);
                        next_row_next = 6'd1;
                        padding_next  = (head.pad_limit > 6'd1);
                        pad_lim_next  = head.pad_limit;
                    end
                end
                else if (pass_reg)
                begin
                    emit          = 1'b1;
                    row_next      = head.src;
                    bytes_next    = src_bytes_reg;
                    num_next      = next_row_reg;
                    eog_next      = head.last;
                    eor_next      = 1'b1;
                    next_row_next = row_inc[5:0];
                end
                else if (next_row_reg < height)
                begin
                    emit          = 1'b1;
                    row_next      = shift_row(head.src, shift_reg)
                                    & top_mask(dest_bytes_reg);
                    bytes_next    = dest_bytes_reg;
                    num_next      = next_row_reg;
                    eog_next      = (row_inc == {1'b0, height});
                    eor_next      = !(head.last && (row_inc < {1'b0, height}));
                    next_row_next = row_inc[5:0];
                    // The last source row brings the bottom padding with it.
                    if (head.last && (row_inc < {1'b0, height}))
                    begin
                        padding_next = 1'b1;
                        pad_lim_next = height;
                    end
                end
            end
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg      <= '0;
            dest_bytes_reg <= '0;
            src_bytes_reg  <= '0;
            pass_reg       <= 1'b0;
            next_row_reg   <= '0;
            padding_reg    <= 1'b0;
            pad_lim_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            shift_reg      <= shift_next;
            dest_bytes_reg <= dest_bytes_next;
            src_bytes_reg  <= src_bytes_next;
            pass_reg       <= pass_next;
            next_row_reg   <= next_row_next;
            padding_reg    <= padding_next;
            pad_lim_reg    <= pad_lim_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge clk)
    begin
        row_reg   <= row_next;
        bytes_reg <= bytes_next;
        num_reg   <= num_next;
        eor_reg   <= eor_next;
        eog_reg   <= eog_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = {7'b0, num_reg, bytes_reg, row_reg};
    assign out_last  = eor_reg;
    assign out_eog   = eog_reg;

endmodule

### rtl/core/glyph_bitmap_cell_aligner_core.sv
// Glyph cell aligner. A header item (kind 0 on s_axis_tuser) opens a glyph and
// each following row item (kind 1) carries one packed source row, first byte in
// the top bits. The block writes a cell of cell_height rows: zero rows above,
// the source rows shifted by x_offset and clipped, zero rows below; a glyph as
// wide as cell_width with both offsets zero passes its rows through unpadded.
// Every row of the cell leaves as one result item, and tlast marks the last
// item caused by one input item. The output side delivers one row per cycle
// while m_axis_tready holds, set by the single row sequencer behind the output
// register. A header without top padding, a passthrough header among them, and a
// source row that falls below the cell emit no row of their own.
// Input items enter through a two-entry command queue, so the input side
// keeps taking items while rows are still going out, until that queue fills.
// Configuration writes are meant for idle periods only.
module glyph_bitmap_cell_aligner_core
    import gbca_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [5:0]  cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // advance_width[5:0], glyph_width[11:6], glyph_height[17:12],
    // x_offset[24:18], y_offset[31:25], source_row[71:32]
    input  logic [71:0] s_axis_tdata,
    // kind[0]
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // cell_row[39:0], row_bytes[42:40], row_number[48:43], zeros[55:49]
    output logic [55:0] m_axis_tdata,
    // end_of_run
    output logic        m_axis_tlast,
    // end_of_glyph[0]
    output logic        m_axis_tuser
);

    logic [5:0] cell_height_reg;
    logic [5:0] cell_width_reg;
    logic [5:0] height;
    logic       push;
    cmd_t       push_cmd;
    logic       queue_full;
    logic       pop;
    cmd_t       head;
    logic       empty;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_height_reg <= CELL_HEIGHT_RESET;
            cell_width_reg  <= CELL_WIDTH_RESET;
        end
        else if (cfg_we)
        begin
            case (reg_index_t'(cfg_addr))
                REG_CELL_HEIGHT: cell_height_reg <= cfg_data;
                REG_CELL_WIDTH:  cell_width_reg  <= cfg_data;
                default:         cell_height_reg <= cell_height_reg;
            endcase
        end
    end

    assign height = eff_height(cell_height_reg);

    gbca_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_kind    (s_axis_tuser),
        .in_data    (s_axis_tdata),
        .height     (height),
        .cell_width (cell_width_reg),
        .push       (push),
        .push_cmd   (push_cmd),
        .queue_full (queue_full)
    );

    gbca_cmd_fifo u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (queue_full),
        .pop      (pop),
        .head     (head),
        .empty    (empty)
    );

    gbca_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (empty),
        .pop       (pop),
        .height    (height),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast),
        .out_eog   (m_axis_tuser)
    );

    // The final row of a cell always closes the run of its input item.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("end of glyph without end of run");

    // Every emitted row carries one to five valid bytes.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[42:40] != 3'd0) && (m_axis_tdata[42:40] <= 3'd5))
        else $error("row byte count out of range");

    // Row numbers stay inside the largest cell.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[48:43] < 6'd40))
        else $error("row number beyond cell");

endmodule
